// ----- rtl/dksc_pkg.sv -----
// ----------------------------------------------------------------------------
// dksc_pkg
// shared types and constants of the digit key shift cipher with padding
// ----------------------------------------------------------------------------
`default_nettype none

package dksc_pkg;

  localparam int LETTER_W    = 5;
  localparam int DIGIT_W     = 4;
  localparam int POS_W       = 4;
  localparam int LEN_W       = 5;
  localparam int KEY_W       = 64;
  localparam int ADDR_W      = 4;
  localparam int MAX_KEY_LEN = 16;

  localparam logic [LETTER_W-1:0] LETTER_Z = LETTER_W'(25);
  localparam logic [LETTER_W:0]   ALPHABET = (LETTER_W + 1)'(26);

  // register index, taken from paddr bit 3 (registers sit 8 bytes apart)
  typedef enum logic {
    REG_KEY_DIGITS = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_digits;
    logic [LEN_W-1:0] eff_len;    // clamped to 1..MAX_KEY_LEN
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/dksc_in_if.sv -----
// ----------------------------------------------------------------------------
// dksc_in_if
// input channel: one plaintext letter per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface dksc_in_if
  import dksc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter_code;
  logic                end_of_message;

  modport source (output valid, output letter_code, output end_of_message, input ready);
  modport sink   (input valid, input letter_code, input end_of_message, output ready);
endinterface

`default_nettype wire

// ----- rtl/dksc_out_if.sv -----
// ----------------------------------------------------------------------------
// dksc_out_if
// output channel: one ciphertext letter per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface dksc_out_if
  import dksc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_code;
  logic                is_padding;
  logic                last_of_run;

  modport source (output valid, output cipher_code, output is_padding, output last_of_run,
                  input ready);
  modport sink   (input valid, input cipher_code, input is_padding, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/dksc_cfg.sv -----
// ----------------------------------------------------------------------------
// dksc_cfg
// apb register file: key digits and key length
// ----------------------------------------------------------------------------
`default_nettype none

module dksc_cfg
  import dksc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [KEY_W-1:0]  pwdata,
  output logic      [KEY_W-1:0]  prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [KEY_W-1:0] key_digits;
  logic [LEN_W-1:0] key_length;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = reg_idx_t'(paddr[3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_digits <= '0;
      key_length <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_DIGITS: key_digits <= pwdata;
        REG_KEY_LENGTH: key_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_DIGITS: prdata = key_digits;
      REG_KEY_LENGTH: prdata = {{(KEY_W-LEN_W){1'b0}}, key_length};
      default:        prdata = '0;
    endcase
  end

  // zero counts as one, anything past the key size as the full key
  always_comb begin
    cfg.key_digits = key_digits;
    priority if (key_length == '0) begin
      cfg.eff_len = LEN_W'(1);
    end else if (key_length > LEN_W'(MAX_KEY_LEN)) begin
      cfg.eff_len = LEN_W'(MAX_KEY_LEN);
    end else begin
      cfg.eff_len = key_length;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dksc_shift_unit.sv -----
// ----------------------------------------------------------------------------
// dksc_shift_unit
// shared shifter: picks the key digit at a position and adds it modulo 26
// ----------------------------------------------------------------------------
`default_nettype none

module dksc_shift_unit
  import dksc_pkg::*;
(
  input  wire logic [LETTER_W-1:0] letter,
  input  wire logic [POS_W-1:0]    pos,
  input  wire logic [KEY_W-1:0]    key_digits,
  output logic      [LETTER_W-1:0] code
);

  logic [DIGIT_W-1:0] digit;
  logic [LETTER_W:0]  sum;
  logic [LETTER_W:0]  wrapped;

  assign digit = key_digits[pos * DIGIT_W +: DIGIT_W];
  assign sum   = (LETTER_W + 1)'(letter) + (LETTER_W + 1)'(digit);

  // sum stays below 52, so one conditional subtract is enough
  assign wrapped = (sum >= ALPHABET) ? (sum - ALPHABET) : sum;
  assign code    = wrapped[LETTER_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/digit_key_shift_cipher_with_padding_unit.sv -----
// ----------------------------------------------------------------------------
// digit_key_shift_cipher_with_padding_unit
// digit key shift cipher; pads the final key round with the smallest letter
// ----------------------------------------------------------------------------
// output: a result sits in the output register in the cycle after its letter is taken
// throughput: one ordinary letter per cycle unless the output stalls; a final letter taken at
//   key position p gives a result for each position from p below the length (at least one),
//   one per cycle from the single shared shift unit unless the output stalls, input held off meanwhile
// reset (synchronous): key position 0, smallest letter Z, key digits 0, key length 1,
//   output empty
`default_nettype none

module digit_key_shift_cipher_with_padding_unit
  import dksc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  dksc_in_if.sink                in_ch,
  dksc_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [KEY_W-1:0]  pwdata,
  output logic      [KEY_W-1:0]  prdata,
  output logic                   pready
);

  typedef enum logic {
    ST_IDLE,
    ST_PAD
  } state_t;

  cfg_t                cfg;
  state_t              state;
  logic [POS_W-1:0]    pos;
  logic [LETTER_W-1:0] smallest;
  logic                out_valid;
  logic [LETTER_W-1:0] out_code;
  logic                out_pad;
  logic                out_last;

  logic                out_free;
  logic                in_fire;
  logic                pad_fire;
  logic [LETTER_W-1:0] su_letter;
  logic [LETTER_W-1:0] su_code;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    pos_next;
  logic [LETTER_W-1:0] smallest_next;

  dksc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign su_letter = (state == ST_PAD) ? smallest : in_ch.letter_code;

  dksc_shift_unit u_shift (
    .letter     (su_letter),
    .pos        (pos),
    .key_digits (cfg.key_digits),
    .code       (su_code)
  );

  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign pad_fire = (state == ST_PAD) && out_free;

  // a position at or past the length (length lowered mid message) wraps to 0
  assign pos_inc  = (POS_W + 1)'(pos) + (POS_W + 1)'(1);
  assign pos_next = (pos_inc >= cfg.eff_len) ? '0 : pos_inc[POS_W-1:0];

  assign smallest_next = (in_ch.letter_code < smallest) ? in_ch.letter_code : smallest;

  assign out_ch.valid       = out_valid;
  assign out_ch.cipher_code = out_code;
  assign out_ch.is_padding  = out_pad;
  assign out_ch.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      smallest  <= LETTER_Z;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid <= 1'b1;
        out_code  <= su_code;
        out_pad   <= 1'b0;
        priority if (in_ch.end_of_message && pos_next != '0) begin
          state    <= ST_PAD;
          pos      <= pos_next;
          smallest <= smallest_next;
          out_last <= 1'b0;
        end else if (in_ch.end_of_message) begin
          pos      <= '0;
          smallest <= LETTER_Z;
          out_last <= 1'b1;
        end else begin
          pos      <= pos_next;
          smallest <= smallest_next;
          out_last <= 1'b1;
        end
      end else if (pad_fire) begin
        out_valid <= 1'b1;
        out_code  <= su_code;
        out_pad   <= 1'b1;
        out_last  <= (pos_next == '0);
        if (pos_next == '0) begin
          state    <= ST_IDLE;
          pos      <= '0;
          smallest <= LETTER_Z;
        end else begin
          pos <= pos_next;
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // padding runs only from a nonzero position
  a_pad_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAD |-> pos != '0)
    else $error("padding with key position 0");

  // ciphertext is always a letter
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_code < LETTER_W'(26))
    else $error("cipher code out of range");

  // smallest letter never rises above Z
  a_smallest: assert property (@(posedge clk) disable iff (rst)
    smallest <= LETTER_Z)
    else $error("smallest letter out of range");

  // a final letter either starts padding or leaves the state cleared
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.end_of_message |=>
      state == ST_PAD || (pos == '0 && smallest == LETTER_Z))
    else $error("state not cleared after final letter");

  // each accepted letter lands in the output register as a non padding beat
  a_letter_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && !out_pad)
    else $error("accepted letter did not reach the output");

endmodule

`default_nettype wire

// ----- tb/sv/digit_key_shift_cipher_with_padding_unit_test.sv -----
// ----------------------------------------------------------------------------
// digit_key_shift_cipher_with_padding_unit_test
// drives letters and key register writes into the digit key shift cipher,
// predicts every cipher beat (padding included) and checks the output stream
// in order, with random idle bursts on the letter and cipher channels
// ----------------------------------------------------------------------------
module digit_key_shift_cipher_with_padding_unit_test
  import dksc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_code;
    logic                is_padding;
    logic                last_of_run;
  } cipher_beat_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [KEY_W-1:0]  pwdata;
  logic [KEY_W-1:0]  prdata;
  logic              pready;

  dksc_in_if  in_ch ();
  dksc_out_if out_ch ();

  digit_key_shift_cipher_with_padding_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [KEY_W-1:0]    key_digits_reg;
  logic [LEN_W-1:0]    key_len_reg;
  logic [POS_W-1:0]    key_pos;
  logic [LETTER_W-1:0] low_letter;

  cipher_beat_t expected_beats[$];
  cipher_beat_t want;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           idling = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic logic [LETTER_W-1:0] shift_code(input logic [LETTER_W-1:0] letter,
                                                     input logic [POS_W-1:0] pos);
    int digit;
    digit = int'(key_digits_reg[pos * DIGIT_W +: DIGIT_W]);
    return LETTER_W'((int'(letter) + digit) % 26);
  endfunction

  function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0] pos, input int len);
    return (int'(pos) + 1 >= len) ? '0 : pos + 1'b1;
  endfunction

  // expected beats for one accepted letter
  function automatic void predict_cipher(input logic [LETTER_W-1:0] letter, input logic eom);
    int               len;
    int               n;
    logic [POS_W-1:0] pos;
    len = int'(key_len_reg);
    if (len == 0) len = 1;
    if (len > MAX_KEY_LEN) len = MAX_KEY_LEN;
    pos = key_pos;
    if (letter < low_letter) low_letter = letter;
    expected_beats.push_back('{shift_code(letter, pos), 1'b0, 1'b0});
    n = 1;
    pos = advance_pos(pos, len);
    if (eom) begin
      // pad out the key round with the message's smallest letter
      while (pos != 0 && n < MAX_KEY_LEN) begin
        expected_beats.push_back('{shift_code(low_letter, pos), 1'b1, 1'b0});
        n++;
        pos = advance_pos(pos, len);
      end
      key_pos = '0;
      low_letter = LETTER_Z;
    end else begin
      key_pos = pos;
    end
    expected_beats[expected_beats.size() - 1].last_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("cipher beat %0d with nothing expected", out_ch.cipher_code));
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.cipher_code !== want.cipher_code)
          report_mismatch($sformatf("cipher_code %0d, expected %0d",
                                    out_ch.cipher_code, want.cipher_code));
        if (out_ch.is_padding !== want.is_padding)
          report_mismatch($sformatf("is_padding %0b, expected %0b",
                                    out_ch.is_padding, want.is_padding));
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                    out_ch.last_of_run, want.last_of_run));
      end
    end
  end

  // cipher side stalls
  initial begin
    int stall;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(5) == 0) begin
        stall = $urandom_range(8, 1);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic eom);
    int gap;
    if (idling && $urandom_range(3) == 0) begin
      gap = $urandom_range(8, 1);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.letter_code    <= letter;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    predict_cipher(letter, eom);
  endtask

  // stop sending and let every expected beat come out
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [KEY_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_KEY_DIGITS) key_digits_reg = value;
    else key_len_reg = value[LEN_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_reset_values();
    // zero key, length one: letters pass straight through
    send_letter(LETTER_W'(0), 1'b0);
    send_letter(LETTER_Z, 1'b1);
  endtask

  task automatic test_field_extremes();
    write_reg(REG_KEY_DIGITS, '1);
    write_reg(REG_KEY_LENGTH, KEY_W'(MAX_KEY_LEN));
    send_letter(LETTER_W'(31), 1'b0);
    send_letter(LETTER_W'(0), 1'b1);
    // final letter at position 0 of a full key gives the longest run
    send_letter(LETTER_Z, 1'b1);
  endtask

  task automatic test_length_clamp();
    write_reg(REG_KEY_DIGITS, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_KEY_LENGTH, '0);
    send_letter(LETTER_W'(3), 1'b0);
    send_letter(LETTER_W'(4), 1'b1);
    write_reg(REG_KEY_LENGTH, KEY_W'(31));
    send_letter(LETTER_W'(7), 1'b1);
    write_reg(REG_KEY_LENGTH, KEY_W'(17));
    send_letter(LETTER_W'(26), 1'b0);
    send_letter(LETTER_W'(2), 1'b1);
  endtask

  task automatic test_length_cut_mid_message();
    write_reg(REG_KEY_DIGITS, 64'h1357_9BDF_2468_ACE0);
    write_reg(REG_KEY_LENGTH, KEY_W'(8));
    for (int i = 0; i < 5; i++) send_letter(LETTER_W'(20 - i), 1'b0);
    // position now beyond the shorter key, digit still used, then wrap
    write_reg(REG_KEY_LENGTH, KEY_W'(3));
    send_letter(LETTER_W'(9), 1'b0);
    send_letter(LETTER_W'(1), 1'b0);
    send_letter(LETTER_W'(5), 1'b0);
    send_letter(LETTER_W'(11), 1'b0);
    write_reg(REG_KEY_LENGTH, KEY_W'(1));
    send_letter(LETTER_W'(6), 1'b1);
  endtask

  task automatic test_random_messages();
    int                  phase_items;
    int                  msg_len;
    bit                  cut;
    logic [LETTER_W-1:0] letter;
    for (int phase = 0; phase < 6; phase++) begin
      idling = (phase != 5);
      case (phase)
        0: begin
          write_reg(REG_KEY_DIGITS, '1);
          write_reg(REG_KEY_LENGTH, KEY_W'(MAX_KEY_LEN));
        end
        1: begin
          write_reg(REG_KEY_DIGITS, '0);
          write_reg(REG_KEY_LENGTH, KEY_W'(1));
        end
        default: begin
          write_reg(REG_KEY_DIGITS, {$urandom, $urandom});
          write_reg(REG_KEY_LENGTH, KEY_W'($urandom_range(31)));
        end
      endcase
      phase_items = 0;
      while (phase_items < 15) begin
        msg_len = $urandom_range(20, 1);
        cut = ($urandom_range(5) == 0);
        for (int i = 0; i < msg_len; i++) begin
          if (cut && i > 0 && i == msg_len / 2)
            write_reg(REG_KEY_LENGTH, KEY_W'($urandom_range(16, 1)));
          // mostly real letters, now and then a code past Z
          letter = ($urandom_range(7) == 0) ? LETTER_W'($urandom_range(31, 26))
                                            : LETTER_W'($urandom_range(25));
          send_letter(letter, i == msg_len - 1);
          phase_items++;
        end
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.letter_code    = '0;
    in_ch.end_of_message = 1'b0;
    key_digits_reg       = '0;
    key_len_reg          = LEN_W'(1);
    key_pos              = '0;
    low_letter           = LETTER_Z;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_field_extremes();
    test_length_clamp();
    test_length_cut_mid_message();
    test_random_messages();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dksc_pkg.sv
rtl/dksc_in_if.sv
rtl/dksc_out_if.sv
rtl/dksc_cfg.sv
rtl/dksc_shift_unit.sv
rtl/digit_key_shift_cipher_with_padding_unit.sv
tb/sv/digit_key_shift_cipher_with_padding_unit_test.sv
